// ===== rtl/lmd_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the draw engine.
package lmd_pkg;

   // Panel geometry and frame store layout
   localparam int PANEL_SIZE   = 32;
   localparam int HALF_ROWS    = 16;
   localparam int COLOR_PLANES = 3;
   localparam int PATTERN_SPAN = 8;

   // Visible rows are limited by both the panel and the two half-row banks
   localparam int PANEL_ROWS = (PANEL_SIZE < 2 * HALF_ROWS) ? PANEL_SIZE : 2 * HALF_ROWS;
   localparam int MEM_DEPTH  = PANEL_ROWS * PANEL_SIZE;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   // One word per pixel: R, G, B bit of every plane
   localparam int WORD_W     = 3 * COLOR_PLANES;

   // Payload field widths
   localparam int COORD_W = 5;
   localparam int SPAN_W  = 4;
   localparam int PAT_W   = 64;
   localparam int CHAN_W  = 8;
   // Pixel position after adding a pattern offset, wide enough for any panel bound
   localparam int POS_W   = 7;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_GET  = 2'd1,
      CMD_FILL = 2'd2,
      CMD_DRAW = 2'd3
   } cmd_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic walk_step;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic req_get;
      logic clear_last;
      logic walk_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

// ===== rtl/lmd_req_if.sv =====
// Command channel: valid/ready handshake with the drawing command payload.
interface lmd_req_if import lmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [COORD_W-1:0]  row;
   logic [COORD_W-1:0]  col;
   logic [COORD_W-1:0]  row_end;
   logic [COORD_W-1:0]  col_end;
   logic [SPAN_W-1:0]   pat_height;
   logic [SPAN_W-1:0]   pat_width;
   logic [PAT_W-1:0]    pattern_bits;
   logic [CHAN_W-1:0]   red;
   logic [CHAN_W-1:0]   green;
   logic [CHAN_W-1:0]   blue;
   logic                overwrite;

   modport source (
      output valid, cmd, row, col, row_end, col_end, pat_height, pat_width,
             pattern_bits, red, green, blue, overwrite,
      input  ready
   );

   modport sink (
      input  valid, cmd, row, col, row_end, col_end, pat_height, pat_width,
             pattern_bits, red, green, blue, overwrite,
      output ready
   );
endinterface

// ===== rtl/lmd_rsp_if.sv =====
// Result channel: valid/ready handshake with the pixel color read back.
interface lmd_rsp_if import lmd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  red_out;
   logic [CHAN_W-1:0]  green_out;
   logic [CHAN_W-1:0]  blue_out;

   modport source (
      output valid, red_out, green_out, blue_out,
      input  ready
   );

   modport sink (
      input  valid, red_out, green_out, blue_out,
      output ready
   );
endinterface

// ===== rtl/lmd_ctrl.sv =====
// Controller state machine: clearing pass, command acceptance, pixel walk and read reply.
module lmd_ctrl import lmd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.walk_step  = 1'b0;
      cmd.rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_get ? ST_READ : ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_IDLE;
            end
         end
         // read address is stable, data lands in the read register
         ST_READ: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/lmd_datapath.sv =====
// Datapath: command registers, pixel walk counters, frame store memory and result register.
module lmd_datapath import lmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status,
   input  logic [1:0]          req_cmd,
   input  logic [COORD_W-1:0]  req_row,
   input  logic [COORD_W-1:0]  req_col,
   input  logic [COORD_W-1:0]  req_row_end,
   input  logic [COORD_W-1:0]  req_col_end,
   input  logic [SPAN_W-1:0]   req_pat_height,
   input  logic [SPAN_W-1:0]   req_pat_width,
   input  logic [PAT_W-1:0]    req_pattern_bits,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic                req_overwrite,
   lmd_rsp_if.source           rsp_chan
);

   // Captured command
   logic [COORD_W-1:0] row_ff, col_ff;
   logic [COORD_W-1:0] last_i_ff, last_i_in, last_j_ff, last_j_in;
   logic               empty_ff, empty_in;
   logic               pat_mode_ff, pat_mode_in;
   logic               ovw_ff;
   logic [PAT_W-1:0]   pattern_ff;
   logic [WORD_W-1:0]  color_ff, color_in;

   // Walk counters and clearing counter
   logic [COORD_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;

   // Frame store and read register
   logic [WORD_W-1:0]  frame_mem [MEM_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr, rd_addr;
   logic [WORD_W-1:0]  mem_wdata;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0]  red_in, green_in, blue_in;

   logic [SPAN_W-1:0]  ph_clamp, pw_clamp;
   logic [POS_W-1:0]   pix_row, pix_col, get_row, get_col;
   logic               pix_on, get_on, pat_bit, paint, walk_last;
   logic [ADDR_W-1:0]  pix_addr;

   // Decode the incoming command into walk bounds and packed color
   always_comb begin
      ph_clamp = (req_pat_height > SPAN_W'(PATTERN_SPAN)) ? SPAN_W'(PATTERN_SPAN)
                                                           : req_pat_height;
      pw_clamp = (req_pat_width > SPAN_W'(PATTERN_SPAN)) ? SPAN_W'(PATTERN_SPAN)
                                                          : req_pat_width;
      last_i_in   = '0;
      last_j_in   = '0;
      empty_in    = 1'b0;
      pat_mode_in = 1'b0;
      unique case (cmd_type'(req_cmd))
         CMD_SET, CMD_GET: begin
            last_i_in = '0;
            last_j_in = '0;
         end
         CMD_FILL: begin
            empty_in  = (req_row > req_row_end) || (req_col > req_col_end);
            last_i_in = req_row_end - req_row;
            last_j_in = req_col_end - req_col;
         end
         CMD_DRAW: begin
            pat_mode_in = 1'b1;
            empty_in    = (ph_clamp == '0) || (pw_clamp == '0);
            last_i_in   = COORD_W'(ph_clamp - SPAN_W'(1));
            last_j_in   = COORD_W'(pw_clamp - SPAN_W'(1));
         end
         default: begin
            empty_in = 1'b1;
         end
      endcase
      // plane k keeps bit 7-k of each channel
      for (int k = 0; k < COLOR_PLANES; k++) begin
         color_in[3*k]     = req_red[7-k];
         color_in[3*k + 1] = req_green[7-k];
         color_in[3*k + 2] = req_blue[7-k];
      end
   end

   // Current walk pixel: position, clipping, pattern bit
   always_comb begin
      pix_row  = POS_W'(row_ff) + POS_W'(i_ff);
      pix_col  = POS_W'(col_ff) + POS_W'(j_ff);
      pix_on   = (pix_row < POS_W'(PANEL_ROWS)) && (pix_col < POS_W'(PANEL_SIZE));
      pix_addr = ADDR_W'(ADDR_W'(pix_row) * ADDR_W'(PANEL_SIZE) + ADDR_W'(pix_col));
      // pattern row i is byte i, column j is bit 7-j of it
      pat_bit  = pattern_ff[{i_ff[2:0], ~j_ff[2:0]}];
      paint    = !pat_mode_ff || pat_bit;
      walk_last = empty_ff || ((i_ff == last_i_ff) && (j_ff == last_j_ff));
   end

   // Read address for get pixel
   always_comb begin
      get_row = POS_W'(row_ff);
      get_col = POS_W'(col_ff);
      get_on  = (get_row < POS_W'(PANEL_ROWS)) && (get_col < POS_W'(PANEL_SIZE));
      rd_addr = ADDR_W'(ADDR_W'(get_row) * ADDR_W'(PANEL_SIZE) + ADDR_W'(get_col));
   end

   // Single write port: clearing pass or walk
   always_comb begin
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = cmd.walk_step && !empty_ff && pix_on && (paint || ovw_ff);
         mem_addr  = pix_addr;
         mem_wdata = paint ? color_ff : '0;
      end
   end

   // Walk counters: columns inner, rows outer
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.load) begin
         i_in = '0;
         j_in = '0;
      end else if (cmd.walk_step) begin
         if (j_ff == last_j_ff) begin
            j_in = '0;
            i_in = i_ff + COORD_W'(1);
         end else begin
            j_in = j_ff + COORD_W'(1);
         end
      end
      clr_in = cmd.clear_step ? clr_ff + ADDR_W'(1) : clr_ff;
   end

   // Result register, freed by a transfer on the result channel
   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (get_on) begin
         for (int k = 0; k < COLOR_PLANES; k++) begin
            red_in[7-k]   = rd_data_ff[3*k];
            green_in[7-k] = rd_data_ff[3*k + 1];
            blue_in[7-k]  = rd_data_ff[3*k + 2];
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff      <= req_row;
         col_ff      <= req_col;
         last_i_ff   <= last_i_in;
         last_j_ff   <= last_j_in;
         empty_ff    <= empty_in;
         pat_mode_ff <= pat_mode_in;
         ovw_ff      <= req_overwrite;
         pattern_ff  <= req_pattern_bits;
         color_ff    <= color_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      if (cmd.rsp_load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   assign status.req_get    = (cmd_type'(req_cmd) == CMD_GET);
   assign status.clear_last = (clr_ff == ADDR_W'(MEM_DEPTH - 1));
   assign status.walk_last  = walk_last;
   assign status.rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = red_ff;
   assign rsp_chan.green_out = green_ff;
   assign rsp_chan.blue_out  = blue_ff;

endmodule

// ===== rtl/led_matrix_bitplane_draw_engine_unit.sv =====
// Top level of the LED panel draw engine: controller plus datapath on two handshake channels.
// One command at a time. Set pixel: the pixel is written in the walk state, then idle again. Get
// pixel: the frame store is read in the read state and the result register is loaded in the reply
// state once it is free. Fill and draw pattern: the walk visits each pixel of the rectangle or
// clamped pattern area (one step for an empty area) through the single frame store write port.
// Synchronous active-high reset, then a clearing pass with req ready low over all 1024 words.
module led_matrix_bitplane_draw_engine_unit import lmd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lmd_req_if.sink    req_chan,
   lmd_rsp_if.source  rsp_chan
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type dp_status;
   logic            req_ready;

   lmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   assign req_chan.ready = req_ready;

   lmd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .req_cmd          (req_chan.cmd),
      .req_row          (req_chan.row),
      .req_col          (req_chan.col),
      .req_row_end      (req_chan.row_end),
      .req_col_end      (req_chan.col_end),
      .req_pat_height   (req_chan.pat_height),
      .req_pat_width    (req_chan.pat_width),
      .req_pattern_bits (req_chan.pattern_bits),
      .req_red          (req_chan.red),
      .req_green        (req_chan.green),
      .req_blue         (req_chan.blue),
      .req_overwrite    (req_chan.overwrite),
      .rsp_chan         (rsp_chan)
   );

endmodule
